// ===== rtl/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// Types and constants shared by the gain ramp mixer: item layouts, the
// per-pair state entry, ramp mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
package grm_pkg;

  // Sample and gain widths
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned GAIN_W      = 24;
  localparam int unsigned FACTOR_W    = 16;
  localparam int unsigned SLOPE_W     = GAIN_W + 1;

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = GAIN_W + 2;
  localparam int unsigned MUL_B_W = GAIN_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_RECIPROCAL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_THRESHOLD = 2'd3;

  // Register values after reset
  localparam logic [FACTOR_W-1:0] SMOOTHING_RESET = 16'd65208;
  localparam logic [GAIN_W-1:0]   RECIP_RESET     = 24'd32768;
  localparam logic [GAIN_W-1:0]   THRESH_RESET    = 24'd168;

  // Ramp modes, as kept per pair
  typedef enum logic [1:0] {
    MODE_HOLD    = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_POLE    = 2'd2,
    MODE_SILENCE = 2'd3
  } grm_mode_e;

  // Input beat
  typedef struct packed {
    logic [3:0]                    source_index;
    logic [5:0]                    speaker_index;
    logic [GAIN_W-1:0]             target_gain;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [SAMPLE_BITS-1:0] mix_in;
    logic                          block_start;
    logic                          skip;
  } grm_in_t;

  // Output beat
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mix_out;
    logic [GAIN_W-1:0]             gain_now;
  } grm_out_t;

  // Per-pair state entry held in the state memory
  typedef struct packed {
    logic [GAIN_W-1:0]         gain;
    logic signed [SLOPE_W-1:0] slope;
    grm_mode_e                 mode;
    logic [GAIN_W-1:0]         target;
  } grm_entry_t;

endpackage

// ===== rtl/grm_ram.sv =====
// ----------------------------------------------------------------------------
// grm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module grm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gain_ramp_mixer_core.sv =====
// ----------------------------------------------------------------------------
// gain_ramp_mixer_core
// Per source/speaker gain smoother with saturating multiply-accumulate.
// ----------------------------------------------------------------------------
// Each input beat carries one sample of one source for one speaker; the block
// reads that pair's state (gain, slope, mode, latched target) from a single
// synchronous memory, updates the gain (jump, linear ramp or one-pole
// approach), adds sample times gain to mix_in with saturation, writes the
// state back and returns one output beat. Items are handled one at a time and
// all products go through one shared 26x25 multiplier. An item passes the read
// state, on a block start the slope and decide states, then the gain state,
// the pole state for a one-pole or silence approach, the multiply state unless
// held below the threshold or gone silent, and the done state; a skipped or
// out-of-range item goes from read straight to done. The sequencer returns to
// idle before the next item is accepted; the result register lets the next
// item be accepted while a result waits. After reset a clearing pass writes
// NUM_SOURCES*NUM_SPEAKERS memory entries, one a cycle, during which input is
// stalled; configuration writes are always accepted.
// ----------------------------------------------------------------------------
module gain_ramp_mixer_core #(
  parameter int unsigned NUM_SOURCES  = 16,
  parameter int unsigned NUM_SPEAKERS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  grm_pkg::grm_in_t                    in_data_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output grm_pkg::grm_out_t                   out_data_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [grm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [grm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import grm_pkg::*;

  localparam int unsigned PAIRS   = NUM_SOURCES * NUM_SPEAKERS;
  localparam int unsigned PAIR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned ENTRY_W = $bits(grm_entry_t);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_READ   = 4'd2;
  localparam logic [3:0] ST_SLOPE  = 4'd3;
  localparam logic [3:0] ST_DECIDE = 4'd4;
  localparam logic [3:0] ST_GAIN   = 4'd5;
  localparam logic [3:0] ST_POLE   = 4'd6;
  localparam logic [3:0] ST_MAC    = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  localparam logic signed [SAMPLE_BITS+3:0] SMP_MAX =
    (SAMPLE_BITS+4)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SAMPLE_BITS+3:0] SMP_MIN =
    (SAMPLE_BITS+4)'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [MUL_P_W-1:0] ROUND_HALF = MUL_P_W'(64'sd1 <<< (GAIN_W - 1));

  // Configuration registers
  logic                linear_q;
  logic [FACTOR_W-1:0] smooth_q;
  logic [GAIN_W-1:0]   recip_q;
  logic [GAIN_W-1:0]   thresh_q;

  // Control state
  logic [3:0]        state_q, state_d;
  logic [PAIR_W-1:0] clr_q, clr_d;
  logic              range_q, range_d;
  logic              wb_q, wb_d;
  logic              mac_q, mac_d;
  logic              out_valid_q, out_valid_d;

  // Item and working registers
  grm_in_t                    item_q;
  logic [PAIR_W-1:0]          pair_q;
  logic [GAIN_W-1:0]          g_q, g_d;
  logic signed [SLOPE_W-1:0]  slope_q, slope_d;
  grm_mode_e                  mode_q, mode_d;
  logic [GAIN_W-1:0]          tgt_q, tgt_d;
  logic [GAIN_W-1:0]          mag_q, mag_d;
  logic                       neg_q, neg_d;
  logic signed [MUL_P_W-1:0]  mul_q;
  grm_out_t                   out_data_q, out_data_d;

  // Memory ports
  logic              ram_we, ram_re;
  logic [PAIR_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  grm_entry_t        rd_entry, wr_entry;

  // Handshake helpers
  logic in_accept, out_load, out_free, mul_en;
  logic [IDX_W-1:0] pair_full;
  logic             pair_in_range;

  // Multiplier operands
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  // Arithmetic paths
  logic [GAIN_W-1:0]          slope_mag;
  logic signed [SLOPE_W-1:0]  slope_new;
  logic signed [GAIN_W+1:0]   lin_sum, lin_tgt, lin_val;
  logic [GAIN_W-1:0]          lin_gain;
  logic signed [SLOPE_W-1:0]  pole_diff;
  logic signed [GAIN_W+16:0]  pole_p, pole_sum;
  logic [GAIN_W-1:0]          pole_gain;
  logic signed [MUL_P_W-1:0]  mac_round;
  logic signed [SAMPLE_BITS+3:0] mac_sum, mac_sat;
  logic signed [SAMPLE_BITS-1:0] res_mix;

  // Configuration writes, taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_q <= 1'b0;
      smooth_q <= SMOOTHING_RESET;
      recip_q  <= RECIP_RESET;
      thresh_q <= THRESH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LINEAR_MODE:       linear_q <= cfg_data_i[0];
        CFG_SMOOTHING_FACTOR:  smooth_q <= cfg_data_i[FACTOR_W-1:0];
        CFG_BLOCK_RECIPROCAL:  recip_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_SILENCE_THRESHOLD: thresh_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pair address and range check for the incoming beat
  assign pair_full = IDX_W'(in_data_i.source_index) * IDX_W'(NUM_SPEAKERS)
                   + IDX_W'(in_data_i.speaker_index);
  assign pair_in_range = (32'(in_data_i.source_index) < 32'(NUM_SOURCES)) &&
                         (32'(in_data_i.speaker_index) < 32'(NUM_SPEAKERS));

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;

  // State memory: read on accept, write back on result, zero while clearing
  assign ram_re    = in_accept;
  assign ram_raddr = pair_full[PAIR_W-1:0];
  assign rd_entry  = grm_entry_t'(ram_rdata);

  always_comb begin
    wr_entry.gain   = g_q;
    wr_entry.slope  = slope_q;
    wr_entry.mode   = mode_q;
    wr_entry.target = tgt_q;
  end

  assign ram_we    = (state_q == ST_CLEAR) || (out_load && wb_q);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : pair_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : ENTRY_W'(wr_entry);

  grm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAIRS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Slope from the registered product, signed by the direction of the change
  assign slope_mag = mul_q[2*GAIN_W-1:GAIN_W];
  assign slope_new = neg_q ? -$signed({1'b0, slope_mag}) : $signed({1'b0, slope_mag});

  // Linear step, clamped at the latched target and to the gain range
  assign lin_tgt = $signed({2'b00, tgt_q});
  assign lin_sum = $signed({2'b00, g_q}) + $signed({slope_q[SLOPE_W-1], slope_q});

  always_comb begin
    lin_val = lin_sum;
    if (!slope_q[SLOPE_W-1] && (slope_q != '0) && (lin_sum > lin_tgt)) begin
      lin_val = lin_tgt;
    end else if (slope_q[SLOPE_W-1] && (lin_sum < lin_tgt)) begin
      lin_val = lin_tgt;
    end
    if (lin_val[GAIN_W+1]) begin
      lin_gain = '0;
    end else if (lin_val[GAIN_W]) begin
      lin_gain = '1;
    end else begin
      lin_gain = lin_val[GAIN_W-1:0];
    end
  end

  // One-pole: truncate the scaled distance toward zero, then add the target
  assign pole_diff = $signed({1'b0, g_q}) - $signed({1'b0, tgt_q});
  assign pole_p    = mul_q[GAIN_W+16:0];
  assign pole_sum  = pole_p + (pole_p[GAIN_W+16] ? (GAIN_W+17)'(17'h0FFFF) : '0);
  assign pole_gain = tgt_q + pole_sum[GAIN_W+15:16];

  // Round half up, add to the mix and saturate
  assign mac_round = mul_q + ROUND_HALF;
  assign mac_sum   = $signed({{4{item_q.mix_in[SAMPLE_BITS-1]}}, item_q.mix_in})
                   + $signed({mac_round[MUL_P_W-1], mac_round[MUL_P_W-1:GAIN_W]});

  always_comb begin
    if (mac_sum > SMP_MAX) begin
      mac_sat = SMP_MAX;
    end else if (mac_sum < SMP_MIN) begin
      mac_sat = SMP_MIN;
    end else begin
      mac_sat = mac_sum;
    end
  end

  assign res_mix = mac_q ? mac_sat[SAMPLE_BITS-1:0] : item_q.mix_in;

  always_comb begin
    out_data_d.mix_out  = res_mix;
    out_data_d.gain_now = g_q;
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state_q)
      ST_SLOPE: begin
        mul_a  = $signed({2'b00, mag_q});
        mul_b  = $signed({1'b0, recip_q});
        mul_en = 1'b1;
      end
      ST_GAIN: begin
        mul_a  = $signed({pole_diff[SLOPE_W-1], pole_diff});
        mul_b  = $signed({(MUL_B_W-FACTOR_W)'(0), smooth_q});
        mul_en = 1'b1;
      end
      ST_MAC: begin
        mul_a  = $signed({{(MUL_A_W-SAMPLE_BITS){item_q.in_sample[SAMPLE_BITS-1]}},
                          item_q.in_sample});
        mul_b  = $signed({1'b0, g_q});
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    range_d     = range_q;
    wb_d        = wb_q;
    mac_d       = mac_q;
    g_d         = g_q;
    slope_d     = slope_q;
    mode_d      = mode_q;
    tgt_d       = tgt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        if (clr_q == PAIR_W'(PAIRS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          range_d = pair_in_range;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // capture the pair's entry
        g_d     = range_q ? rd_entry.gain : '0;
        slope_d = rd_entry.slope;
        mode_d  = rd_entry.mode;
        tgt_d   = rd_entry.target;
        neg_d   = item_q.target_gain < rd_entry.gain;
        mag_d   = neg_d ? (rd_entry.gain - item_q.target_gain)
                        : (item_q.target_gain - rd_entry.gain);
        wb_d    = range_q && !item_q.skip;
        mac_d   = 1'b0;
        if (!range_q || item_q.skip) begin
          state_d = ST_DONE;
        end else if (item_q.block_start) begin
          state_d = ST_SLOPE;
        end else begin
          state_d = ST_GAIN;
        end
      end
      ST_SLOPE: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // pick the mode for this block
        tgt_d   = item_q.target_gain;
        slope_d = slope_new;
        if ((slope_mag == '0) || (mag_q < thresh_q)) begin
          mode_d = MODE_HOLD;
          g_d    = item_q.target_gain;
        end else if (linear_q) begin
          mode_d = MODE_LINEAR;
        end else if (item_q.target_gain < thresh_q) begin
          mode_d = MODE_SILENCE;
        end else begin
          mode_d = MODE_POLE;
        end
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        case (mode_q)
          MODE_LINEAR: begin
            g_d     = lin_gain;
            mac_d   = 1'b1;
            state_d = ST_MAC;
          end
          MODE_POLE, MODE_SILENCE: begin
            if ((mode_q == MODE_SILENCE) && (g_q < thresh_q)) begin
              mac_d   = 1'b0;
              state_d = ST_DONE;
            end else begin
              state_d = ST_POLE;
            end
          end
          default: begin
            mac_d   = (g_q >= thresh_q);
            state_d = (g_q >= thresh_q) ? ST_MAC : ST_DONE;
          end
        endcase
      end
      ST_POLE: begin
        g_d     = pole_gain;
        mac_d   = 1'b1;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      range_q     <= 1'b0;
      wb_q        <= 1'b0;
      mac_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      range_q     <= range_d;
      wb_q        <= wb_d;
      mac_q       <= mac_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
      pair_q <= pair_full[PAIR_W-1:0];
    end
    g_q     <= g_d;
    slope_q <= slope_d;
    mode_q  <= mode_d;
    tgt_q   <= tgt_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // One port at a time on the state memory
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("state memory read and written in the same cycle");

  // Nothing leaves the block before the clearing pass is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_load && !in_accept)
    else $error("item handled during clearing pass");

  // Out-of-range pair reports zero gain and the untouched mix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !range_q) |=> (out_data_q.gain_now == '0) &&
                               (out_data_q.mix_out == item_q.mix_in))
    else $error("out-of-range pair result wrong");

  // A skipped or out-of-range item never writes state back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && (!range_q || item_q.skip) |-> !wb_q)
    else $error("write-back on skipped item");
`endif

endmodule
